[hw/rtl/ucpe_pkg.sv]
// Shared types, constants and lookup functions for the URL percent encoder.
package ucpe_pkg;

	localparam logic [7:0] CHAR_PCT   = 8'h25;
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_PIPE  = 8'h7C;
	localparam logic [7:0] CHAR_DEL   = 8'h7F;

	localparam int unsigned NUM_COMP = 11;
	localparam logic [NUM_COMP-1:0] COMP_ALL = '1;

	typedef enum logic [2:0] {
		REG_COMPONENT_MASK = 3'd0,
		REG_FORCE_PERCENT  = 3'd1,
		REG_ONLY_ASCII     = 3'd2,
		REG_ONLY_NON_ASCII = 3'd3,
		REG_ESCAPE_COLON   = 3'd4,
		REG_ESCAPE_SPACE   = 3'd5,
		REG_DROP_MASK_LOW  = 3'd6,
		REG_DROP_MASK_HIGH = 3'd7
	} ucpe_reg_t;

	typedef enum logic [1:0] {
		BEAT_PCT = 2'd0,
		BEAT_HI  = 2'd1,
		BEAT_LO  = 2'd2
	} ucpe_beat_t;

	typedef struct packed {
		logic [7:0] in_char;
		logic       end_of_string;
	} ucpe_in_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       last_of_run;
	} ucpe_out_t;

	typedef struct packed {
		logic [NUM_COMP-1:0] component_mask;
		logic                force_percent;
		logic                only_ascii;
		logic                only_non_ascii;
		logic                escape_colon;
		logic                escape_space;
		logic [63:0]         drop_mask_low;
		logic [63:0]         drop_mask_high;
	} ucpe_cfg_t;

	typedef struct packed {
		logic [7:0] chr;
		logic       esc;
	} ucpe_item_t;

	// per-character component set: bit 0 scheme .. bit 10 external handler
	function automatic logic [NUM_COMP-1:0] safe_bits(input logic [6:0] c);
		logic [NUM_COMP-1:0] r;
		case (c) inside
			[7'h00:7'h1F], 7'h20, 7'h22, 7'h25, 7'h3C, 7'h3E, 7'h7F: r = '0;
			7'h23:                                    r = 11'd1536;
			7'h27:                                    r = 11'd1648;
			7'h2E:                                    r = 11'd1977;
			7'h2F:                                    r = 11'd1808;
			7'h3A, 7'h3B, 7'h3D, 7'h40, 7'h5B, 7'h5D: r = 11'd2032;
			7'h3F:                                    r = 11'd1792;
			7'h5C, 7'h5E, 7'h7B, 7'h7D:               r = 11'd896;
			7'h60:                                    r = 11'd384;
			7'h7C:                                    r = 11'd1012;
			default:                                  r = COMP_ALL;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h37 + {4'h0, n});
	endfunction

endpackage

[hw/rtl/ucpe_cfg.sv]
// APB register file holding the encoder mode bits and drop masks.
module ucpe_cfg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [5:0]           paddr,
	input  logic [63:0]          pwdata,
	output logic [63:0]          prdata,
	output logic                 pready,
	output ucpe_pkg::ucpe_cfg_t  cfg
);
	import ucpe_pkg::*;

	ucpe_cfg_t cfg_q;
	ucpe_reg_t idx;
	logic      wr;

	assign idx    = ucpe_reg_t'(paddr[5:3]);
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr) begin
			unique case (idx)
				REG_COMPONENT_MASK: cfg_q.component_mask <= pwdata[NUM_COMP-1:0];
				REG_FORCE_PERCENT:  cfg_q.force_percent  <= pwdata[0];
				REG_ONLY_ASCII:     cfg_q.only_ascii     <= pwdata[0];
				REG_ONLY_NON_ASCII: cfg_q.only_non_ascii <= pwdata[0];
				REG_ESCAPE_COLON:   cfg_q.escape_colon   <= pwdata[0];
				REG_ESCAPE_SPACE:   cfg_q.escape_space   <= pwdata[0];
				REG_DROP_MASK_LOW:  cfg_q.drop_mask_low  <= pwdata;
				REG_DROP_MASK_HIGH: cfg_q.drop_mask_high <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_COMPONENT_MASK: prdata = {{(64-NUM_COMP){1'b0}}, cfg_q.component_mask};
			REG_FORCE_PERCENT:  prdata = {63'd0, cfg_q.force_percent};
			REG_ONLY_ASCII:     prdata = {63'd0, cfg_q.only_ascii};
			REG_ONLY_NON_ASCII: prdata = {63'd0, cfg_q.only_non_ascii};
			REG_ESCAPE_COLON:   prdata = {63'd0, cfg_q.escape_colon};
			REG_ESCAPE_SPACE:   prdata = {63'd0, cfg_q.escape_space};
			REG_DROP_MASK_LOW:  prdata = cfg_q.drop_mask_low;
			REG_DROP_MASK_HIGH: prdata = cfg_q.drop_mask_high;
			default:            prdata = '0;
		endcase
	end

endmodule

[hw/rtl/ucpe_in_stage.sv]
// Input register, drop/escape classification and non-ASCII history.
module ucpe_in_stage (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  ucpe_pkg::ucpe_in_t    in_beat,
	input  ucpe_pkg::ucpe_cfg_t   cfg,
	input  logic                  out_free,
	output logic                  emit_valid,
	output ucpe_pkg::ucpe_item_t  emit_item
);
	import ucpe_pkg::*;

	logic       valid_s1;
	ucpe_in_t   beat_s1;
	logic       prev_non_ascii_q;
	logic [7:0] c;
	logic       is_ascii;
	logic       drop;
	logic       pass;
	logic       go;

	assign c        = beat_s1.in_char;
	assign is_ascii = ~c[7];

	always_comb begin
		drop = is_ascii & (c[6] ? cfg.drop_mask_high[c[5:0]] : cfg.drop_mask_low[c[5:0]]);
		pass = (is_ascii && |(safe_bits(c[6:0]) & cfg.component_mask))
			|| (c == CHAR_PCT && !cfg.force_percent)
			|| (!is_ascii && cfg.only_ascii)
			|| (c >= CHAR_SPACE && c < CHAR_DEL && cfg.only_non_ascii);
		if (c == CHAR_COLON && cfg.escape_colon)
			pass = 1'b0;
		if (c == CHAR_SPACE && cfg.escape_space)
			pass = 1'b0;
		if (prev_non_ascii_q && c == CHAR_PIPE && !cfg.only_ascii)
			pass = 1'b0;
	end

	assign go         = valid_s1 & (drop | out_free);
	assign in_stall   = valid_s1 & ~go;
	assign emit_valid = valid_s1 & ~drop;
	assign emit_item  = '{chr: c, esc: ~pass};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1         <= 1'b0;
			prev_non_ascii_q <= 1'b0;
		end else begin
			if (!in_stall)
				valid_s1 <= in_valid;
			if (go) begin
				if (!drop)
					prev_non_ascii_q <= c[7] & ~beat_s1.end_of_string;
				else if (beat_s1.end_of_string)
					prev_non_ascii_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid)
			beat_s1 <= in_beat;
	end

endmodule

[hw/rtl/ucpe_out_stage.sv]
// Result register that emits one byte or a three-byte escape sequence.
module ucpe_out_stage (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  emit_valid,
	input  ucpe_pkg::ucpe_item_t  emit_item,
	output logic                  out_free,
	output logic                  out_valid,
	input  logic                  out_stall,
	output ucpe_pkg::ucpe_out_t   out_beat
);
	import ucpe_pkg::*;

	logic       valid_q;
	ucpe_item_t item_q;
	ucpe_beat_t beat_q;
	ucpe_beat_t beat_d;
	logic       last;

	assign last      = ~item_q.esc | (beat_q == BEAT_LO);
	assign out_free  = ~valid_q | (last & ~out_stall);
	assign out_valid = valid_q;

	always_comb begin
		out_beat.last_of_run = last;
		if (!item_q.esc) begin
			out_beat.out_char = item_q.chr;
		end else begin
			unique case (beat_q)
				BEAT_PCT: out_beat.out_char = CHAR_PCT;
				BEAT_HI:  out_beat.out_char = hex_char(item_q.chr[7:4]);
				BEAT_LO:  out_beat.out_char = hex_char(item_q.chr[3:0]);
				default:  out_beat.out_char = CHAR_PCT;
			endcase
		end
	end

	always_comb begin
		beat_d = beat_q;
		if (out_free) begin
			beat_d = BEAT_PCT;
		end else if (!out_stall) begin
			unique case (beat_q)
				BEAT_PCT: beat_d = BEAT_HI;
				BEAT_HI:  beat_d = BEAT_LO;
				default:  beat_d = BEAT_PCT;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			beat_q  <= BEAT_PCT;
		end else begin
			beat_q <= beat_d;
			if (out_free)
				valid_q <= emit_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && emit_valid)
			item_q <= emit_item;
	end

endmodule

[hw/rtl/url_component_percent_encoder_top.sv]
// Top level of the URL component percent encoder.
//
//   port group   | direction | beat contents
//   in_*         | in        | raw byte, end of string flag
//   out_*        | out       | output byte, last byte of run flag
//   p*           | in/out    | APB register access, 8 regs at 8-byte stride
//
// Each byte passes through the input register and then the result register.
// A passed byte is emitted as itself, an escaped byte as a three-byte escape sequence, a dropped byte not at all.
// Throughput is bound by the single-byte result port, which holds the input register while it emits an escape.
// Reset clears both stage valids, the non-ASCII history and all configuration registers.
// An output stall holds the result register and backs up into the input register.
module url_component_percent_encoder_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  ucpe_pkg::ucpe_in_t   in_beat,
	output logic                 out_valid,
	input  logic                 out_stall,
	output ucpe_pkg::ucpe_out_t  out_beat,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [5:0]           paddr,
	input  logic [63:0]          pwdata,
	output logic [63:0]          prdata,
	output logic                 pready
);
	import ucpe_pkg::*;

	ucpe_cfg_t  cfg;
	logic       out_free;
	logic       emit_valid;
	ucpe_item_t emit_item;

	ucpe_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ucpe_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_beat    (in_beat),
		.cfg        (cfg),
		.out_free   (out_free),
		.emit_valid (emit_valid),
		.emit_item  (emit_item)
	);

	ucpe_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.emit_valid (emit_valid),
		.emit_item  (emit_item),
		.out_free   (out_free),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_beat   (out_beat)
	);

endmodule

[hw/rtl/ucpe_checker.sv]
// Port-level checks for the URL percent encoder, bound to the top level.
module ucpe_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_stall,
	input ucpe_pkg::ucpe_out_t  out_beat,
	input logic                 pready
);
	import ucpe_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_beat))
		else $error("output beat changed under stall");

	// escape runs are emitted without gaps
	a_run_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_beat.last_of_run |=> out_valid)
		else $error("gap inside escape run");

	// '%' opening an escape is followed by the non-final high digit
	a_pct_then_hi: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_beat.last_of_run && out_beat.out_char == CHAR_PCT
		|=> !out_beat.last_of_run)
		else $error("escape run shorter than three beats");

	// high digit is followed by the final low digit
	a_hi_then_lo: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_beat.last_of_run && out_beat.out_char != CHAR_PCT
		|=> out_beat.last_of_run)
		else $error("escape run longer than three beats");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

endmodule

bind url_component_percent_encoder_top ucpe_checker u_ucpe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_beat  (out_beat),
	.pready    (pready)
);

[tb/tb_url_component_percent_encoder_top.sv]
// Testbench for the URL component percent encoder: predicted byte stream vs. DUT over APB configs.
module tb_url_component_percent_encoder_top;
	import ucpe_pkg::*;

	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned SETTLE_CYCLES = 16;

	class url_escape_tracker;
		ucpe_cfg_t   cfg;
		logic        after_high;
		ucpe_out_t   owed_bytes[$];
		int unsigned errors;

		function new();
			cfg = '0;
			after_high = 1'b0;
			errors = 0;
		endfunction

		function logic [10:0] comp_set(input logic [6:0] c);
			logic [10:0] s;
			if (c < 7'h20) begin
				return 11'd0;
			end
			case (c)
				7'h20, 7'h22, 7'h25, 7'h3C, 7'h3E, 7'h7F: s = 11'd0;
				7'h23: s = 11'd1536;
				7'h27: s = 11'd1648;
				7'h2E: s = 11'd1977;
				7'h2F: s = 11'd1808;
				7'h3A, 7'h3B, 7'h3D, 7'h40, 7'h5B, 7'h5D: s = 11'd2032;
				7'h3F: s = 11'd1792;
				7'h5C, 7'h5E, 7'h7B, 7'h7D: s = 11'd896;
				7'h60: s = 11'd384;
				7'h7C: s = 11'd1012;
				default: s = 11'h7FF;
			endcase
			return s;
		endfunction

		function logic [7:0] hex_digit(input logic [3:0] n);
			return (n < 4'd10) ? (8'h30 + 8'(n)) : (8'h41 + 8'(n) - 8'd10);
		endfunction

		function void write_reg(input ucpe_reg_t r, input logic [63:0] v);
			case (r)
				REG_COMPONENT_MASK: cfg.component_mask = v[10:0];
				REG_FORCE_PERCENT:  cfg.force_percent = v[0];
				REG_ONLY_ASCII:     cfg.only_ascii = v[0];
				REG_ONLY_NON_ASCII: cfg.only_non_ascii = v[0];
				REG_ESCAPE_COLON:   cfg.escape_colon = v[0];
				REG_ESCAPE_SPACE:   cfg.escape_space = v[0];
				REG_DROP_MASK_LOW:  cfg.drop_mask_low = v;
				REG_DROP_MASK_HIGH: cfg.drop_mask_high = v;
				default: ;
			endcase
		endfunction

		function void take_byte(input ucpe_in_t b);
			logic [7:0] c;
			logic       dropped;
			logic       pass;
			ucpe_out_t  o;
			c = b.in_char;
			dropped = !c[7] && (c[6] ? cfg.drop_mask_high[c[5:0]] : cfg.drop_mask_low[c[5:0]]);
			if (dropped) begin
				if (b.end_of_string)
					after_high = 1'b0;
				return;
			end
			pass = (!c[7] && ((comp_set(c[6:0]) & cfg.component_mask) != 11'd0))
				|| (c == CHAR_PCT && !cfg.force_percent)
				|| (c[7] && cfg.only_ascii)
				|| (c >= CHAR_SPACE && c < CHAR_DEL && cfg.only_non_ascii);
			if (c == CHAR_COLON && cfg.escape_colon)
				pass = 1'b0;
			if (c == CHAR_SPACE && cfg.escape_space)
				pass = 1'b0;
			if (after_high && c == CHAR_PIPE && !cfg.only_ascii)
				pass = 1'b0;
			if (pass) begin
				o.out_char = c;
				o.last_of_run = 1'b1;
				owed_bytes.push_back(o);
			end else begin
				o.out_char = CHAR_PCT;
				o.last_of_run = 1'b0;
				owed_bytes.push_back(o);
				o.out_char = hex_digit(c[7:4]);
				owed_bytes.push_back(o);
				o.out_char = hex_digit(c[3:0]);
				o.last_of_run = 1'b1;
				owed_bytes.push_back(o);
			end
			after_high = c[7] && !b.end_of_string;
		endfunction

		function void check_byte(input ucpe_out_t got);
			ucpe_out_t want;
			if (owed_bytes.size() == 0) begin
				$error("unexpected beat: out_char expected none, actual %h", got.out_char);
				errors++;
				return;
			end
			want = owed_bytes.pop_front();
			if (got.out_char !== want.out_char) begin
				$error("out_char expected %h actual %h", want.out_char, got.out_char);
				errors++;
			end
			if (got.last_of_run !== want.last_of_run) begin
				$error("last_of_run expected %b actual %b", want.last_of_run, got.last_of_run);
				errors++;
			end
		endfunction

		function int unsigned pending();
			return owed_bytes.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	ucpe_in_t    in_beat;
	logic        out_valid;
	logic        out_stall = 1'b0;
	ucpe_out_t   out_beat;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [5:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	int unsigned src_idle_pct = 0;
	int unsigned snk_idle_pct = 0;
	int unsigned idle_cycles = 0;
	int unsigned sent;

	url_escape_tracker tracker = new();

	url_component_percent_encoder_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_beat(in_beat),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_beat(out_beat),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #4 clk = ~clk;

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < snk_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				tracker.take_byte(in_beat);
			if (out_valid && !out_stall)
				tracker.check_byte(out_beat);
		end
	end

	always @(posedge clk) begin
		if (arst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		while (idle_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("tb_url_component_percent_encoder_top NOT OK");
		$finish;
	end

	task automatic send_byte(input logic [7:0] c, input logic eos);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_beat <= '{in_char: c, end_of_string: eos};
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		sent++;
	endtask

	// stop sending and wait out every owed beat plus pipeline slack
	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic apb_write(input ucpe_reg_t r, input logic [63:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 3'b000};
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tracker.write_reg(r, v);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [63:0] pad(input logic [63:0] v, input int w);
		logic [63:0] junk;
		junk = {$urandom(), $urandom()};
		return (w >= 64) ? v : ((junk << w) | v);
	endfunction

	task automatic load_config(input ucpe_cfg_t c);
		apb_write(REG_COMPONENT_MASK, pad(64'(c.component_mask), 11));
		apb_write(REG_FORCE_PERCENT, pad(64'(c.force_percent), 1));
		apb_write(REG_ONLY_ASCII, pad(64'(c.only_ascii), 1));
		apb_write(REG_ONLY_NON_ASCII, pad(64'(c.only_non_ascii), 1));
		apb_write(REG_ESCAPE_COLON, pad(64'(c.escape_colon), 1));
		apb_write(REG_ESCAPE_SPACE, pad(64'(c.escape_space), 1));
		apb_write(REG_DROP_MASK_LOW, c.drop_mask_low);
		apb_write(REG_DROP_MASK_HIGH, c.drop_mask_high);
	endtask

	function automatic ucpe_cfg_t pick_config(input int kind);
		ucpe_cfg_t c;
		c.component_mask = 11'($urandom());
		c.force_percent = 1'($urandom());
		c.only_ascii = 1'($urandom());
		c.only_non_ascii = 1'($urandom());
		c.escape_colon = 1'($urandom());
		c.escape_space = 1'($urandom());
		c.drop_mask_low = {$urandom(), $urandom()} & {$urandom(), $urandom()}
			& {$urandom(), $urandom()};
		c.drop_mask_high = {$urandom(), $urandom()} & {$urandom(), $urandom()}
			& {$urandom(), $urandom()};
		if (kind == 0) begin
			c = '0;
		end else if (kind == 1) begin
			c = '1;
		end else if (kind == 2) begin
			c.component_mask = '1;
			c.drop_mask_low = '0;
			c.drop_mask_high = '0;
		end
		return c;
	endfunction

	function automatic logic [7:0] pick_char();
		int unsigned k;
		k = $urandom_range(99);
		if (k < 40) return 8'($urandom_range(8'h7E, 8'h20));
		if (k < 55) return 8'($urandom_range(8'hFF, 8'h80));
		if (k < 65) return CHAR_PIPE;
		if (k < 71) return CHAR_PCT;
		if (k < 77) return CHAR_COLON;
		if (k < 83) return CHAR_SPACE;
		if (k < 91) return ($urandom_range(7) == 0) ? CHAR_DEL : 8'($urandom_range(8'h1F));
		return 8'($urandom());
	endfunction

	// mostly whole strings ending in end_of_string, a few with the flag scrambled
	task automatic send_strings(input int unsigned count, input bit mid_pause);
		int unsigned start;
		int unsigned len;
		logic        eos;
		start = sent;
		while (sent - start < count) begin
			len = $urandom_range(10, 1);
			for (int unsigned i = 0; i < len; i++) begin
				eos = (i == len - 1);
				if ($urandom_range(9) == 0)
					eos = ~eos;
				send_byte(pick_char(), eos);
			end
			if (mid_pause && sent - start >= count / 2) begin
				drain();
				mid_pause = 0;
			end
		end
	endtask

	initial begin
		ucpe_cfg_t c;
		sent = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_beat = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		src_idle_pct = 11;
		snk_idle_pct = 54;

		// reset config: only '%' passes
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(CHAR_PIPE, 1'b0);
		send_byte(8'h80, 1'b1);
		send_byte(CHAR_PIPE, 1'b0);
		send_byte(CHAR_PCT, 1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(CHAR_DEL, 1'b1);
		drain();

		c = '0;
		c.component_mask = '1;
		c.force_percent = 1'b1;
		c.only_non_ascii = 1'b1;
		c.escape_colon = 1'b1;
		c.escape_space = 1'b1;
		c.drop_mask_low = 64'h2;
		c.drop_mask_high = 64'h1 << 58;
		load_config(c);
		send_byte(CHAR_COLON, 1'b0);
		send_byte(CHAR_SPACE, 1'b0);
		send_byte(8'h61, 1'b0);
		send_byte(CHAR_PCT, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h02, 1'b0);
		send_byte(8'hC3, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(CHAR_PIPE, 1'b0);
		send_byte(8'hE9, 1'b0);
		send_byte(8'h7A, 1'b1);
		send_byte(CHAR_PIPE, 1'b1);
		drain();

		apb_write(REG_ONLY_ASCII, 64'd1);
		send_byte(8'hC3, 1'b0);
		send_byte(CHAR_PIPE, 1'b1);
		drain();

		for (int p = 0; p < 6; p++) begin
			if (p == 2) begin
				src_idle_pct = 54;
				snk_idle_pct = 11;
			end else if (p == 4) begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			load_config(pick_config(p));
			send_strings(38, p == 3);
			drain();
		end

		if (tracker.errors == 0)
			$display("tb_url_component_percent_encoder_top OK");
		else
			$display("tb_url_component_percent_encoder_top NOT OK");
		$finish;
	end

endmodule
